[rtl/core/rtcm_pkg.sv]
// Shared constants, codes and status types of the three-phase RMS current monitor.
package rtcm_pkg;

   // Defaults of the top-level parameters.
   localparam int MAX_WINDOW_DEFAULT = 128;
   localparam int CODE_BITS_DEFAULT  = 12;

   // Fixed widths of registers and result fields.
   localparam int WLEN_BITS      = 8;
   localparam int SCALE_BITS     = 20;
   localparam int OUT_BITS       = 16;
   localparam int FRAC_BITS      = 16;
   localparam int CSR_DATA_BITS  = 20;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [WLEN_BITS-1:0]  WLEN_RESET  = 8'd100;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 20'd352086;
   localparam logic [OUT_BITS-1:0]   OUT_MAX     = 16'hFFFF;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UA_PER_COUNT  = 1'd1;

   // Item kinds.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

[rtl/core/rtcm_front.sv]
// Front end: accepts request beats and turns them into queued commands.
module rtcm_front #(
   parameter int CODE_BITS = rtcm_pkg::CODE_BITS_DEFAULT
) (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [CODE_BITS-1:0]          req_offset_code,
   input  logic [CODE_BITS-1:0]          req_phase_a_code,
   input  logic [CODE_BITS-1:0]          req_phase_b_code,
   input  logic [CODE_BITS-1:0]          req_phase_c_code,
   input  rtcm_pkg::queue_status_type    q_status,
   input  rtcm_pkg::back_status_type     back_status,
   output logic                          push,
   output logic [3*CODE_BITS:0]          push_data
);

   logic [CODE_BITS-1:0] diff_a;
   logic [CODE_BITS-1:0] diff_b;
   logic [CODE_BITS-1:0] diff_c;

   // Distance of each phase code from the offset reference.
   always_comb begin
      diff_a = (req_phase_a_code >= req_offset_code) ? req_phase_a_code - req_offset_code
                                                     : req_offset_code - req_phase_a_code;
      diff_b = (req_phase_b_code >= req_offset_code) ? req_phase_b_code - req_offset_code
                                                     : req_offset_code - req_phase_b_code;
      diff_c = (req_phase_c_code >= req_offset_code) ? req_phase_c_code - req_offset_code
                                                     : req_offset_code - req_phase_c_code;
   end

   assign req_ready = !q_status.full && !back_status.clearing;
   assign push      = req_valid && req_ready;
   assign push_data = {req_kind, diff_c, diff_b, diff_a};

endmodule

[rtl/core/rtcm_queue.sv]
// Two-entry command queue between the front and back ends.
module rtcm_queue #(
   parameter int DATA_BITS = 1 + 3 * rtcm_pkg::CODE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [DATA_BITS-1:0]       push_data,
   input  logic                       pop,
   output logic [DATA_BITS-1:0]       pop_data,
   output rtcm_pkg::queue_status_type status
);

   localparam int PTR_BITS   = $clog2(rtcm_pkg::QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(rtcm_pkg::QUEUE_DEPTH + 1);

   logic [DATA_BITS-1:0]  entry_ff [rtcm_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [COUNT_BITS-1:0] count_ff;

   assign status.full  = (count_ff == COUNT_BITS'(rtcm_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(rtcm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(rtcm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[rtl/core/rtcm_back.sv]
// Back end: sample store, window walk, divider, square root, scaling and result register.
module rtcm_back #(
   parameter int MAX_WINDOW = rtcm_pkg::MAX_WINDOW_DEFAULT,
   parameter int CODE_BITS  = rtcm_pkg::CODE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [rtcm_pkg::WLEN_BITS-1:0]       window_length,
   input  logic [rtcm_pkg::SCALE_BITS-1:0]      microamps_per_count,
   input  logic [3*CODE_BITS:0]                 cmd_data,
   input  rtcm_pkg::queue_status_type           q_status,
   output logic                                 pop,
   output rtcm_pkg::back_status_type            status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [rtcm_pkg::OUT_BITS-1:0]        rsp_phase_a_microamps,
   output logic [rtcm_pkg::OUT_BITS-1:0]        rsp_phase_b_microamps,
   output logic [rtcm_pkg::OUT_BITS-1:0]        rsp_phase_c_microamps
);

   localparam int LANES      = 3;
   localparam int IDX_BITS   = $clog2(MAX_WINDOW);
   localparam int CNT_BITS   = $clog2(MAX_WINDOW + 1);
   localparam int CMP_BITS   = (CNT_BITS > rtcm_pkg::WLEN_BITS) ? CNT_BITS : rtcm_pkg::WLEN_BITS;
   localparam int WORD_BITS  = LANES * CODE_BITS;
   localparam int SUM_BITS   = 2 * CODE_BITS + CNT_BITS;
   localparam int STEP_BITS  = $clog2(SUM_BITS + 1);
   localparam int SQ_BITS    = (SUM_BITS + 1) / 2;
   localparam int RAD_BITS   = 2 * SQ_BITS;
   localparam int SREM_BITS  = SQ_BITS + 2;
   localparam int PROD_BITS  = CODE_BITS + rtcm_pkg::SCALE_BITS;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DIV,
      ST_SQRT,
      ST_MUL,
      ST_OUT
   } state_type;

   state_type             state_ff;
   logic [CNT_BITS-1:0]   issue_ff;
   logic [CNT_BITS-1:0]   fill_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic                  rd_v_ff;
   logic                  sq_v_ff;
   logic                  rsp_valid_ff;

   logic [WORD_BITS-1:0]  mem [MAX_WINDOW];
   logic [WORD_BITS-1:0]  rdata_ff;

   logic [2*CODE_BITS-1:0] sq_ff   [LANES];
   logic [SUM_BITS-1:0]    sum_ff  [LANES];
   logic [CNT_BITS-1:0]    rem_ff  [LANES];
   logic [RAD_BITS-1:0]    rad_ff  [LANES];
   logic [SREM_BITS-1:0]   srem_ff [LANES];
   logic [SQ_BITS-1:0]     root_ff [LANES];
   logic [PROD_BITS-1:0]   prod_ff [LANES];
   logic [rtcm_pkg::OUT_BITS-1:0] out_ff [LANES];

   logic [CMP_BITS-1:0]   wl_ext;
   logic [CNT_BITS-1:0]   win;
   logic                  cmd_kind;
   logic                  mem_we;
   logic [IDX_BITS-1:0]   mem_waddr;
   logic [WORD_BITS-1:0]  mem_wdata;
   logic                  mem_re;
   logic                  walk_done;
   logic                  out_load;

   logic [SUM_BITS-1:0]    quo_in  [LANES];
   logic [CNT_BITS-1:0]    rem_in  [LANES];
   logic [RAD_BITS-1:0]    rad_in  [LANES];
   logic [SREM_BITS-1:0]   srem_in [LANES];
   logic [SQ_BITS-1:0]     root_in [LANES];
   logic [rtcm_pkg::OUT_BITS-1:0] sat_in [LANES];

   // Window length in use: zero counts as one, large values stop at the store depth.
   always_comb begin
      wl_ext = CMP_BITS'(window_length);
      if (window_length == '0) begin
         win = CNT_BITS'(1);
      end else if (wl_ext > CMP_BITS'(MAX_WINDOW)) begin
         win = CNT_BITS'(MAX_WINDOW);
      end else begin
         win = CNT_BITS'(wl_ext);
      end
   end

   assign cmd_kind  = cmd_data[WORD_BITS];
   assign pop       = (state_ff == ST_IDLE) && !q_status.empty;
   assign mem_re    = (state_ff == ST_WALK) && (issue_ff < win);
   assign walk_done = (state_ff == ST_WALK) && !mem_re && !rd_v_ff && !sq_v_ff;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = issue_ff[IDX_BITS-1:0];
      mem_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (pop && (cmd_kind == rtcm_pkg::KIND_SAMPLE) && (fill_ff < win)) begin
         mem_we    = 1'b1;
         mem_waddr = fill_ff[IDX_BITS-1:0];
         mem_wdata = cmd_data[WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= mem[issue_ff[IDX_BITS-1:0]];
      end
   end

   // One restoring-divide step, one square-root step and the saturation of the scaled product, per lane.
   always_comb begin
      logic [CNT_BITS:0]    trial_div;
      logic                 div_ge;
      logic [SQ_BITS+3:0]   cur;
      logic [SQ_BITS+3:0]   trial_sq;
      logic                 sq_ge;
      logic [PROD_BITS-1:0] shifted;
      for (int p = 0; p < LANES; p++) begin
         trial_div  = {rem_ff[p], sum_ff[p][SUM_BITS-1]};
         div_ge     = trial_div >= (CNT_BITS + 1)'(win);
         rem_in[p]  = div_ge ? CNT_BITS'(trial_div - (CNT_BITS + 1)'(win))
                             : CNT_BITS'(trial_div);
         quo_in[p]  = {sum_ff[p][SUM_BITS-2:0], div_ge};

         cur         = {srem_ff[p], rad_ff[p][RAD_BITS-1 -: 2]};
         trial_sq    = {2'b00, root_ff[p], 2'b01};
         sq_ge       = cur >= trial_sq;
         srem_in[p]  = sq_ge ? SREM_BITS'(cur - trial_sq) : SREM_BITS'(cur);
         root_in[p]  = {root_ff[p][SQ_BITS-2:0], sq_ge};
         rad_in[p]   = {rad_ff[p][RAD_BITS-3:0], 2'b00};

         shifted    = prod_ff[p] >> rtcm_pkg::FRAC_BITS;
         sat_in[p]  = (shifted > PROD_BITS'(rtcm_pkg::OUT_MAX)) ? rtcm_pkg::OUT_MAX
                                                             : shifted[rtcm_pkg::OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      // Payload and datapath registers, no reset needed.
      if (rd_v_ff) begin
         for (int p = 0; p < LANES; p++) begin
            sq_ff[p] <= (2*CODE_BITS)'(rdata_ff[p*CODE_BITS +: CODE_BITS])
                        * (2*CODE_BITS)'(rdata_ff[p*CODE_BITS +: CODE_BITS]);
         end
      end
      for (int p = 0; p < LANES; p++) begin
         if (state_ff == ST_IDLE) begin
            sum_ff[p] <= '0;
         end else if (state_ff == ST_WALK && sq_v_ff) begin
            sum_ff[p] <= sum_ff[p] + SUM_BITS'(sq_ff[p]);
         end else if (state_ff == ST_DIV) begin
            sum_ff[p] <= quo_in[p];
         end
         if (state_ff == ST_WALK) begin
            rem_ff[p] <= '0;
         end else if (state_ff == ST_DIV) begin
            rem_ff[p] <= rem_in[p];
         end
         if (state_ff == ST_DIV) begin
            rad_ff[p]  <= RAD_BITS'(quo_in[p]);
            srem_ff[p] <= '0;
            root_ff[p] <= '0;
         end else if (state_ff == ST_SQRT) begin
            rad_ff[p]  <= rad_in[p];
            srem_ff[p] <= srem_in[p];
            root_ff[p] <= root_in[p];
         end
         if (state_ff == ST_MUL) begin
            prod_ff[p] <= PROD_BITS'(root_ff[p][CODE_BITS-1:0]) * PROD_BITS'(microamps_per_count);
         end
         if (out_load) begin
            out_ff[p] <= sat_in[p];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         issue_ff     <= '0;
         fill_ff      <= '0;
         step_ff      <= '0;
         rd_v_ff      <= 1'b0;
         sq_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_v_ff <= mem_re;
         sq_v_ff <= rd_v_ff;
         // A new result may land in the same cycle that the previous one is taken.
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               issue_ff <= issue_ff + 1'b1;
               if (issue_ff == CNT_BITS'(MAX_WINDOW - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (pop) begin
                  if (cmd_kind == rtcm_pkg::KIND_REPORT) begin
                     fill_ff  <= '0;
                     issue_ff <= '0;
                     state_ff <= ST_WALK;
                  end else if (fill_ff < win) begin
                     fill_ff <= fill_ff + 1'b1;
                  end
               end
            end
            ST_WALK: begin
               if (mem_re) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               if (walk_done) begin
                  step_ff  <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= ST_SQRT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_SQRT: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_BITS'(SQ_BITS - 1)) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign status.clearing       = (state_ff == ST_CLEAR);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_phase_a_microamps = out_ff[0];
   assign rsp_phase_b_microamps = out_ff[1];
   assign rsp_phase_c_microamps = out_ff[2];

endmodule

[rtl/core/three_phase_rms_current_monitor_core.sv]
// Top level of the three-phase windowed RMS current monitor.
//
// Each request beat is either a sample set (offset reference plus three phase ADC codes) or a
// report command. A sample stores the distance of each phase code from the offset reference at
// the current fill position, as long as the fill count is below the window length; later samples
// are dropped until the next report. A report walks the whole window (stale entries included),
// forms per phase the mean of the squares, its floor square root and the product with the Q16
// microamps-per-count scale, saturates to 16 bits, returns one response beat and clears the fill
// count. The front end takes request beats into a two-entry command queue, so it can take up to
// two beats while the back end works or while a response waits to be taken. Samples flow at one
// beat per cycle while the back end is idle. A report occupies the back end for a window walk
// (one store read per entry of the window length in use), then bit-serial division and
// bit-serial square root, and finally scaling and result load. After reset the sample store is
// swept to zero, during which no request beat is accepted; configuration writes are taken at
// any time but are meant only while the block is idle.
module three_phase_rms_current_monitor_core #(
   parameter int MAX_WINDOW = rtcm_pkg::MAX_WINDOW_DEFAULT,
   parameter int CODE_BITS  = rtcm_pkg::CODE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [rtcm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rtcm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [CODE_BITS-1:0]                  req_offset_code,
   input  logic [CODE_BITS-1:0]                  req_phase_a_code,
   input  logic [CODE_BITS-1:0]                  req_phase_b_code,
   input  logic [CODE_BITS-1:0]                  req_phase_c_code,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rtcm_pkg::OUT_BITS-1:0]         rsp_phase_a_microamps,
   output logic [rtcm_pkg::OUT_BITS-1:0]         rsp_phase_b_microamps,
   output logic [rtcm_pkg::OUT_BITS-1:0]         rsp_phase_c_microamps
);

   localparam int CMD_BITS = 1 + 3 * CODE_BITS;

   logic [rtcm_pkg::WLEN_BITS-1:0]  window_length_ff;
   logic [rtcm_pkg::SCALE_BITS-1:0] ua_per_count_ff;

   rtcm_pkg::queue_status_type q_status;
   rtcm_pkg::back_status_type  back_status;
   logic                       q_push;
   logic [CMD_BITS-1:0]        q_push_data;
   logic                       q_pop;
   logic [CMD_BITS-1:0]        q_pop_data;

   // Configuration registers. There is no read-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= rtcm_pkg::WLEN_RESET;
         ua_per_count_ff  <= rtcm_pkg::SCALE_RESET;
      end else if (csr_we) begin
         if (csr_index == rtcm_pkg::REG_WINDOW_LENGTH) begin
            window_length_ff <= csr_wdata[rtcm_pkg::WLEN_BITS-1:0];
         end else if (csr_index == rtcm_pkg::REG_UA_PER_COUNT) begin
            ua_per_count_ff <= csr_wdata[rtcm_pkg::SCALE_BITS-1:0];
         end
      end
   end

   // The front end computes the per-phase distances from the offset and queues the command.
   rtcm_front #(
      .CODE_BITS (CODE_BITS)
   ) u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_offset_code  (req_offset_code),
      .req_phase_a_code (req_phase_a_code),
      .req_phase_b_code (req_phase_b_code),
      .req_phase_c_code (req_phase_c_code),
      .q_status         (q_status),
      .back_status      (back_status),
      .push             (q_push),
      .push_data        (q_push_data)
   );

   // The queue lets up to two request beats arrive while a report is being worked out.
   rtcm_queue #(
      .DATA_BITS (CMD_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // The back end owns the sample store, the fill count and the arithmetic.
   rtcm_back #(
      .MAX_WINDOW (MAX_WINDOW),
      .CODE_BITS  (CODE_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .window_length         (window_length_ff),
      .microamps_per_count   (ua_per_count_ff),
      .cmd_data              (q_pop_data),
      .q_status              (q_status),
      .pop                   (q_pop),
      .status                (back_status),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_phase_a_microamps (rsp_phase_a_microamps),
      .rsp_phase_b_microamps (rsp_phase_b_microamps),
      .rsp_phase_c_microamps (rsp_phase_c_microamps)
   );

   // No request beat may be taken while the store is being swept after reset.
   assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> !req_ready)
      else $error("request accepted during store clearing");

   // No response can exist before the store sweep has finished.
   assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> !rsp_valid)
      else $error("response valid during store clearing");

   // The front end must never push into a full command queue.
   assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_push)
      else $error("push into full command queue");

   // A command leaves the queue only when one is there.
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty command queue");

endmodule
